/* rtl/tsf_pkg.sv */
`default_nettype none

package tsf_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned TOTAL_W    = 24;
	localparam int unsigned TAG_SET_W  = 64;
	localparam int unsigned TAG_CNT_W  = 4;
	localparam int unsigned CFG_W      = TAG_SET_W;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAG_SET   = 1'b0,
		REG_TAG_COUNT = 1'b1
	} tsf_reg_t;

	typedef enum logic [1:0] {
		PH_TAG    = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_LEN_LO = 2'd2,
		PH_VALUE  = 2'd3
	} tsf_phase_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              buffer_end;
	} tsf_in_t;

	typedef struct packed {
		logic [DATA_W-1:0]  out_byte;
		logic               byte_kept;
		logic               end_of_buffer;
		logic [TOTAL_W-1:0] copied_total;
	} tsf_out_t;

endpackage

`default_nettype wire

/* rtl/tsf_match.sv */
`default_nettype none

module tsf_match #(
	parameter int unsigned MAX_TAGS = 8
) (
	input  wire logic [tsf_pkg::TAG_SET_W-1:0] tag_set,
	input  wire logic [tsf_pkg::TAG_CNT_W-1:0] tag_count,
	input  wire logic [tsf_pkg::DATA_W-1:0]    tag,
	output logic                               hit
);
	import tsf_pkg::*;

	logic [MAX_TAGS-1:0] lane_hit;

	// slot k is live when k < tag_count; k never reaches past MAX_TAGS
	always_comb begin
		for (int k = 0; k < MAX_TAGS; k++) begin
			lane_hit[k] = (TAG_CNT_W'(k) < tag_count) &&
				(tag_set[DATA_W*k +: DATA_W] == tag);
		end
	end

	assign hit = |lane_hit;

endmodule

`default_nettype wire

/* rtl/tsf_parse.sv */
`default_nettype none

module tsf_parse #(
	parameter int unsigned COUNT_BITS = 24
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire tsf_pkg::tsf_in_t beat,
	input  wire logic            tag_hit,
	output tsf_pkg::tsf_out_t    result
);
	import tsf_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	tsf_phase_t            phase_q, phase_n;
	logic                  match_q, match_n;
	logic [LEN_W-1:0]      remain_q, remain_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic [32:0]           count_wide;

	always_comb begin
		phase_n  = phase_q;
		match_n  = match_q;
		remain_n = remain_q;
		case (phase_q)
			PH_TAG: begin
				match_n = tag_hit;
				phase_n = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				remain_n = {beat.data_byte, 8'h00};
				phase_n  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				remain_n = {remain_q[LEN_W-1:DATA_W], beat.data_byte};
				phase_n  = (remain_n == '0) ? PH_TAG : PH_VALUE;
			end
			PH_VALUE: begin
				remain_n = (remain_q != '0) ? remain_q - LEN_W'(1) : remain_q;
				phase_n  = (remain_n == '0) ? PH_TAG : PH_VALUE;
			end
			default: begin
				phase_n = PH_TAG;
			end
		endcase
		count_n = (match_n && count_q != CNT_MAX) ? count_q + COUNT_BITS'(1) : count_q;
	end

	always_comb begin
		count_wide           = 33'(count_n);
		result.out_byte      = match_n ? beat.data_byte : '0;
		result.byte_kept     = match_n;
		result.end_of_buffer = beat.buffer_end;
		result.copied_total  = (count_wide > 33'(TOTAL_MAX)) ? TOTAL_MAX
			: count_wide[TOTAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			match_q  <= 1'b0;
			remain_q <= '0;
			count_q  <= '0;
		end else if (step) begin
			if (beat.buffer_end) begin
				phase_q  <= PH_TAG;
				match_q  <= 1'b0;
				remain_q <= '0;
				count_q  <= '0;
			end else begin
				phase_q  <= phase_n;
				match_q  <= (phase_n == PH_TAG) ? 1'b0 : match_n;
				remain_q <= remain_n;
				count_q  <= count_n;
			end
		end
	end

	// no element is open while a tag byte is expected
	a_tag_clears_match: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAG) |-> !match_q)
		else $error("match flag set while expecting a tag");
	a_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VALUE) |-> (remain_q != '0))
		else $error("value phase with nothing remaining");
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && beat.buffer_end) |=> (count_q == '0 && phase_q == PH_TAG))
		else $error("parser did not restart after buffer end");

endmodule

`default_nettype wire

/* rtl/tlv_tag_set_filter_top.sv */
// TLV tag-set filter.
// item channel: one byte of a tag/length/value buffer per beat, with a flag
// on the buffer's last byte. result channel: exactly one beat per item beat,
// in order, carrying the byte (zeroed when dropped), a kept flag, the end
// flag and the saturating count of bytes kept so far in the buffer.
// An element is kept whole when its tag equals one of the first tag_count
// bytes of tag_set, at most MAX_TAGS of them. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block does not enforce this. It applies from the next tag byte.
// Path: item into the input register, then one pass of phase update and
// parallel tag compare into the result register. Throughput: one item per
// cycle while the result side does not stall; the phase and count update
// is combinational.
// Reset clears the parser, the count, both registers and both pipeline
// stage valid flags. When result_stall is held the result register and the
// input register hold their beats and item_stall rises once both are full.
`default_nettype none

module tlv_tag_set_filter_top #(
	parameter int unsigned MAX_TAGS   = 8,
	parameter int unsigned COUNT_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire tsf_pkg::tsf_in_t              item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output tsf_pkg::tsf_out_t                  result,
	input  wire logic                          cfg_we,
	input  wire logic [tsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsf_pkg::CFG_W-1:0]     cfg_data
);
	import tsf_pkg::*;

	logic [TAG_SET_W-1:0] tag_set_q;
	logic [TAG_CNT_W-1:0] tag_count_q;
	logic                 valid_s1;
	tsf_in_t              item_s1;
	logic                 adv_s2;
	logic                 step;
	logic                 tag_hit;
	tsf_out_t             result_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_set_q   <= '0;
			tag_count_q <= '0;
		end else if (cfg_we) begin
			case (tsf_reg_t'(cfg_index))
				REG_TAG_SET:   tag_set_q   <= cfg_data;
				REG_TAG_COUNT: tag_count_q <= cfg_data[TAG_CNT_W-1:0];
				default:       tag_set_q   <= tag_set_q;
			endcase
		end
	end

	assign adv_s2     = !result_valid || !result_stall;
	assign step       = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	tsf_match #(
		.MAX_TAGS (MAX_TAGS)
	) u_match (
		.tag_set   (tag_set_q),
		.tag_count (tag_count_q),
		.tag       (item_s1.data_byte),
		.hit       (tag_hit)
	);

	tsf_parse #(
		.COUNT_BITS (COUNT_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.beat    (item_s1),
		.tag_hit (tag_hit),
		.result  (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv_s2) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result <= result_n;
		end
	end

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.byte_kept) |-> (result.out_byte == '0))
		else $error("dropped beat carries data");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled with room in the pipeline");
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> result_valid)
		else $error("stepped beat did not reach the result register");
	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost its beat while stalled");

endmodule

`default_nettype wire

/* sim/testbench.sv */
module testbench;
	import tsf_pkg::*;

	localparam int unsigned TAG_LIMIT    = 8;
	localparam int unsigned COUNT_W      = 24;
	localparam int unsigned TAG_SLOTS    = TAG_SET_W / DATA_W;
	localparam int unsigned RANDOM_BEATS = 1600;
	localparam int unsigned PHASE_BEATS  = 200;
	localparam int unsigned HOLD_START   = 700;
	localparam int unsigned HOLD_CYCLES  = 250;
	localparam int unsigned LONG_LEN     = 300;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct {
		tsf_in_t  beat;
		bit       typed;
		tsf_out_t res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid;
	logic                 item_stall;
	tsf_in_t              item;
	logic                 result_valid;
	logic                 result_stall;
	tsf_out_t             result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tlv_tag_set_filter_top #(
		.MAX_TAGS  (TAG_LIMIT),
		.COUNT_BITS(COUNT_W)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// filter state as the block should hold it
	logic [TAG_SET_W-1:0] want_tags;
	logic [TAG_CNT_W-1:0] want_count;
	tsf_phase_t           parse_phase;
	logic                 elem_hit;
	logic [LEN_W-1:0]     value_left;
	logic [COUNT_W-1:0]   kept_count;

	tsf_out_t    filtered_due[$];
	stim_row_t   stim_rows[$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	bit          sender_calm = 1'b1;

	function automatic void clear_parser();
		parse_phase = PH_TAG;
		elem_hit = 1'b0;
		value_left = '0;
		kept_count = '0;
	endfunction

	function automatic logic tag_selected(logic [DATA_W-1:0] tag);
		int unsigned lim;
		logic hit;
		lim = (want_count > TAG_LIMIT) ? TAG_LIMIT : want_count;
		hit = 1'b0;
		for (int k = 0; k < TAG_SLOTS; k++)
			if (k < lim && want_tags[8*k +: 8] == tag)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic tsf_out_t filter_byte(tsf_in_t b);
		tsf_out_t r;
		case (parse_phase)
			PH_TAG: begin
				elem_hit = tag_selected(b.data_byte);
				parse_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				value_left = {b.data_byte, 8'h00};
				parse_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				value_left[7:0] = b.data_byte;
				parse_phase = (value_left == '0) ? PH_TAG : PH_VALUE;
			end
			default: begin
				if (value_left != '0)
					value_left--;
				if (value_left == '0)
					parse_phase = PH_TAG;
			end
		endcase
		if (elem_hit && kept_count != '1)
			kept_count++;
		r.out_byte = elem_hit ? b.data_byte : '0;
		r.byte_kept = elem_hit;
		r.end_of_buffer = b.buffer_end;
		r.copied_total = kept_count;
		if (parse_phase == PH_TAG)
			elem_hit = 1'b0;
		if (b.buffer_end)
			clear_parser();
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s: expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		tsf_out_t due;
		if (arst_n && result_valid && !result_stall) begin
			if (filtered_due.size() == 0) begin
				mismatches++;
				$display("%0t unexpected beat: expected none, got %h", $time, result);
			end else begin
				due = filtered_due.pop_front();
				compare_field("out_byte", due.out_byte, result.out_byte);
				compare_field("byte_kept", due.byte_kept, result.byte_kept);
				compare_field("end_of_buffer", due.end_of_buffer, result.end_of_buffer);
				compare_field("copied_total", due.copied_total, result.copied_total);
			end
		end
	end

	// result side: random stall windows plus one long hold-off
	initial begin
		rx_mode_t mode;
		int unsigned cycle;
		int unsigned window;
		result_stall = 1'b0;
		cycle = 0;
		window = 0;
		mode = RX_FREE;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle == HOLD_START) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				cycle += HOLD_CYCLES;
			end
			if (window == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				window = $urandom_range(20, 120);
			end
			window--;
			case (mode)
				RX_FREE:  result_stall <= 1'b0;
				RX_LIGHT: result_stall <= ($urandom_range(0, 9) < 3);
				RX_HEAVY: result_stall <= ($urandom_range(0, 9) < 8);
				default:  result_stall <= (cycle % 3 == 0);
			endcase
		end
	end

	task automatic send_beat(input tsf_in_t b, input bit typed, input tsf_out_t typed_res);
		int unsigned gap;
		if (!sender_calm) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 30);
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		item <= b;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		filtered_due.push_back(typed ? typed_res : filter_byte(b));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (filtered_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_filter(input logic [TAG_SET_W-1:0] tags,
			input logic [TAG_CNT_W-1:0] count);
		logic [CFG_W-1:0] word;
		word = {$urandom, $urandom};
		word[TAG_CNT_W-1:0] = count;
		cfg_we <= 1'b1;
		cfg_index <= REG_TAG_SET;
		cfg_data <= tags;
		@(posedge clk);
		cfg_index <= REG_TAG_COUNT;
		cfg_data <= word;
		@(posedge clk);
		cfg_we <= 1'b0;
		want_tags = tags;
		want_count = count;
	endtask

	task automatic add_row(input logic [7:0] d, input logic last, input bit typed,
			input logic [7:0] ob, input logic kept, input logic [TOTAL_W-1:0] total);
		stim_row_t row;
		row.beat.data_byte = d;
		row.beat.buffer_end = last;
		row.typed = typed;
		row.res.out_byte = ob;
		row.res.byte_kept = kept;
		row.res.end_of_buffer = last;
		row.res.copied_total = total;
		stim_rows.push_back(row);
	endtask

	task automatic walk_table();
		foreach (stim_rows[i])
			send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].res);
		stim_rows.delete();
	endtask

	task automatic emit_buffer(output int unsigned n);
		logic [7:0] bytes[$];
		logic [7:0] tag;
		logic [15:0] len;
		tsf_in_t beat;
		int unsigned elems, r, vals, slot;
		bit stop;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			elems = $urandom_range(1, 4);
			stop = 1'b0;
			for (int e = 0; e < elems && !stop; e++) begin
				slot = $urandom_range(0, TAG_SLOTS - 1);
				if ($urandom_range(0, 2) != 0)
					tag = want_tags[8*slot +: 8];
				else
					tag = 8'($urandom_range(0, 255));
				r = $urandom_range(0, 99);
				if (r < 10)
					len = '0;
				else if (r < 80)
					len = 16'($urandom_range(1, 8));
				else if (r < 92)
					len = 16'($urandom_range(9, LONG_LEN));
				else
					len = 16'($urandom);
				bytes.push_back(tag);
				bytes.push_back(len[15:8]);
				bytes.push_back(len[7:0]);
				// long elements are cut short by the buffer end
				if (len > LONG_LEN) begin
					vals = $urandom_range(0, 10);
					stop = 1'b1;
				end else begin
					vals = len;
				end
				repeat (vals) bytes.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 4) == 0) begin
				vals = $urandom_range(1, bytes.size());
				while (bytes.size() > vals)
					void'(bytes.pop_back());
			end
		end
		foreach (bytes[i]) begin
			beat.data_byte = bytes[i];
			beat.buffer_end = (i == bytes.size() - 1);
			send_beat(beat, 1'b0, '0);
		end
		n = bytes.size();
	endtask

	initial begin
		int unsigned sent, phase_sent, n, ph;
		logic [TAG_SET_W-1:0] tags;
		logic [TAG_CNT_W-1:0] count;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TAG_SET;
		cfg_data = '0;
		want_tags = '0;
		want_count = '0;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: empty tag set, nothing kept
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 0);
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 0);
		add_row(8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 0);
		add_row(8'h55, 1'b1, 1'b1, 8'h00, 1'b0, 0);
		walk_table();
		drain();

		// count above the slot limit, tags 00 and FF at the extremes
		program_filter(64'h80151413_12A5FF00, 4'd15);
		sender_calm = 1'b0;
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1);
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 2);
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 3);
		add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 4);
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 5);
		add_row(8'h02, 1'b0, 1'b1, 8'h02, 1'b1, 6);
		add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 7);
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 8);
		add_row(8'h42, 1'b0, 1'b1, 8'h00, 1'b0, 8);
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 8);
		add_row(8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 8);
		add_row(8'hAA, 1'b0, 1'b1, 8'h00, 1'b0, 8);
		add_row(8'h80, 1'b0, 1'b1, 8'h80, 1'b1, 9);
		add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 10);
		add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 11);
		add_row(8'h33, 1'b0, 1'b1, 8'h33, 1'b1, 12);
		add_row(8'hCC, 1'b1, 1'b1, 8'hCC, 1'b1, 13);
		add_row(8'hA5, 1'b1, 1'b1, 8'hA5, 1'b1, 1);
		add_row(8'h13, 1'b0, 1'b0, 8'h00, 1'b0, 0);
		add_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 0);
		add_row(8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 0);
		add_row(8'h7E, 1'b1, 1'b0, 8'h00, 1'b0, 0);
		walk_table();
		drain();

		sent = 0;
		ph = 0;
		while (sent < RANDOM_BEATS) begin
			tags = {$urandom, $urandom};
			count = 4'($urandom_range(0, 15));
			case (ph % 8)
				0: begin tags = '0; count = 4'd0; end
				1: begin tags = '1; count = 4'd8; end
				2: count = 4'd15;
				3: count = 4'd1;
				5: begin tags = '1; count = 4'd0; end
				6: count = 4'd2;
				default: ;
			endcase
			program_filter(tags, count);
			sender_calm = (ph % 3 == 1);
			phase_sent = 0;
			while (phase_sent < PHASE_BEATS) begin
				emit_buffer(n);
				phase_sent += n;
			end
			sent += phase_sent;
			drain();
			ph++;
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
